@@ design/caspid_pkg.sv @@
// ----------------------------------------------------------------------------
// Cascaded angle and speed PID: shared types and constants
// Widths, register indexes, controller states and datapath operations used by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package caspid_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int GAIN_FRAC_BITS_DEF  = 16;

	localparam int FIELD_W    = 16;
	localparam int GAIN_W     = 32;
	localparam int INTEG_W    = 32;
	localparam int ERR_W      = 18;
	localparam int DERR_W     = 19;
	localparam int SERR_W     = 17;
	localparam int DSERR_W    = 18;
	localparam int MUL_B_W    = 19;
	localparam int PROD_W     = GAIN_W + MUL_B_W;
	localparam int ACC_W      = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam longint          INT32_TOP = 64'd2147483647;
	localparam logic [FIELD_W-1:0] OUT_CAP = 16'd32767;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KFF = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMITS  = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_AP, ST_AI, ST_AD, ST_AS, ST_AO, ST_TGT,
		ST_SE, ST_SP, ST_SI, ST_SD, ST_SF, ST_SS, ST_SO, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ERR, OP_AP, OP_AI, OP_AD, OP_AS, OP_AO, OP_TGT,
		OP_SE, OP_SP, OP_SI, OP_SD, OP_SF, OP_SS, OP_SO, OP_OUT
	} op_t;

	typedef struct packed {
		logic load_in;
		op_t  op;
	} dp_cmd_t;

	// pi rounded to fb fraction bits.
	function automatic logic signed [ERR_W-1:0] pi_q(input int fb);
		longint unsigned v;
		v = (PI_Q30 + (64'd1 << (29 - fb))) >> (30 - fb);
		return ERR_W'(v);
	endfunction

endpackage

@@ design/caspid_ctrl.sv @@
// ----------------------------------------------------------------------------
// Cascaded angle and speed PID: controller
// Steps the datapath through the outer and inner loop sequence and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module caspid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output caspid_pkg::dp_cmd_t cmd
);
	import caspid_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.load_in = 1'b0;
		cmd.op      = OP_NONE;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_ERR;
				end
			end
			ST_ERR: begin cmd.op = OP_ERR; state_d = ST_AP;  end
			ST_AP:  begin cmd.op = OP_AP;  state_d = ST_AI;  end
			ST_AI:  begin cmd.op = OP_AI;  state_d = ST_AD;  end
			ST_AD:  begin cmd.op = OP_AD;  state_d = ST_AS;  end
			ST_AS:  begin cmd.op = OP_AS;  state_d = ST_AO;  end
			ST_AO:  begin cmd.op = OP_AO;  state_d = ST_TGT; end
			ST_TGT: begin cmd.op = OP_TGT; state_d = ST_SE;  end
			ST_SE:  begin cmd.op = OP_SE;  state_d = ST_SP;  end
			ST_SP:  begin cmd.op = OP_SP;  state_d = ST_SI;  end
			ST_SI:  begin cmd.op = OP_SI;  state_d = ST_SD;  end
			ST_SD:  begin cmd.op = OP_SD;  state_d = ST_SF;  end
			ST_SF:  begin cmd.op = OP_SF;  state_d = ST_SS;  end
			ST_SS:  begin cmd.op = OP_SS;  state_d = ST_SO;  end
			ST_SO:  begin cmd.op = OP_SO;  state_d = ST_OUT; end
			ST_OUT: begin
				// The result register is loaded once the previous item has left.
				if (!out_valid_q || !out_stall) begin
					cmd.op      = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ design/caspid_dp.sv @@
// ----------------------------------------------------------------------------
// Cascaded angle and speed PID: datapath
// Configuration registers, loop state, one shared registered multiplier and a
// wide accumulator with a symmetric clamp.
// ----------------------------------------------------------------------------
module caspid_dp #(
	parameter int ANGLE_FRAC_BITS = caspid_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int GAIN_FRAC_BITS  = caspid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  caspid_pkg::dp_cmd_t                      cmd,
	input  logic                                     cfg_we,
	input  logic [caspid_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [caspid_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [caspid_pkg::FIELD_W-1:0]    angle_setpoint,
	input  logic signed [caspid_pkg::FIELD_W-1:0]    angle_measured,
	input  logic signed [caspid_pkg::FIELD_W-1:0]    speed_measured,
	input  logic                                     wrap_enable,
	output logic signed [caspid_pkg::FIELD_W-1:0]    drive_command,
	output logic signed [caspid_pkg::FIELD_W-1:0]    target_speed,
	output logic                                     drive_saturated
);
	import caspid_pkg::*;

	localparam logic signed [ERR_W-1:0] PI_Q   = pi_q(ANGLE_FRAC_BITS);
	localparam logic signed [ERR_W-1:0] TWO_PI = PI_Q + PI_Q;

	logic signed [GAIN_W-1:0] akp_q, aki_q, akd_q, skp_q, ski_q, skd_q, skff_q;
	logic [CFG_DATA_W-1:0]    limits_q;

	logic signed [FIELD_W-1:0] sp_q, meas_q, rpm_q;
	logic                      wrap_q;

	logic signed [ERR_W-1:0]   err_q, aprev_q;
	logic signed [DERR_W-1:0]  derr_q;
	logic signed [INTEG_W-1:0] aint_q, sint_q;
	logic signed [FIELD_W-1:0] tgt_q;
	logic signed [SERR_W-1:0]  serr_q, sprev_q;
	logic signed [DSERR_W-1:0] dserr_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      sat_q;

	logic signed [FIELD_W-1:0] drive_q, tgt_out_q;
	logic                      sat_out_q;

	logic signed [ERR_W-1:0]   err_raw, err_w;
	logic signed [SERR_W-1:0]  serr_w;
	logic signed [GAIN_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [ACC_W-1:0]   prod_ext, prod_fl;
	logic signed [ACC_W-1:0]   cl_in, cl_bnd, cl_out;
	logic                      cl_hit;
	logic signed [ACC_W-1:0]   ai_bnd, ao_bnd, si_bnd, so_bnd;

	function automatic logic signed [ACC_W-1:0] int_bound(input logic [FIELD_W-1:0] l);
		logic [ACC_W-1:0] b;
		b = {{(ACC_W-FIELD_W){1'b0}}, l} << GAIN_FRAC_BITS;
		if (b > ACC_W'(INT32_TOP))
			b = ACC_W'(INT32_TOP);
		return $signed(b);
	endfunction

	function automatic logic signed [ACC_W-1:0] out_bound(input logic [FIELD_W-1:0] l);
		logic [FIELD_W-1:0] c;
		c = (l > OUT_CAP) ? OUT_CAP : l;
		return $signed({{(ACC_W-FIELD_W){1'b0}}, c} << GAIN_FRAC_BITS);
	endfunction

	// Shift right by the gain fraction, rounding toward zero.
	function automatic logic signed [FIELD_W-1:0] trunc_whole(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] bias;
		logic signed [ACC_W-1:0] s;
		bias = $signed({{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{v[ACC_W-1]}}});
		s    = (v + bias) >>> GAIN_FRAC_BITS;
		return s[FIELD_W-1:0];
	endfunction

	assign ai_bnd = int_bound(limits_q[15:0]);
	assign ao_bnd = out_bound(limits_q[31:16]);
	assign si_bnd = int_bound(limits_q[47:32]);
	assign so_bnd = out_bound(limits_q[63:48]);

	// Angle error, wrapped once into plus or minus pi when requested.
	always_comb begin
		err_raw = ERR_W'(sp_q) - ERR_W'(meas_q);
		err_w   = err_raw;
		if (wrap_q) begin
			if (err_raw > PI_Q)
				err_w = err_raw - TWO_PI;
			else if (err_raw < -PI_Q)
				err_w = err_raw + TWO_PI;
		end
	end

	assign serr_w = SERR_W'(tgt_q) - SERR_W'(rpm_q);

	// Outer loop products carry angle fraction bits and are floored away.
	assign prod_ext = ACC_W'(prod_q);
	assign prod_fl  = prod_ext >>> ANGLE_FRAC_BITS;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_AP:   begin mul_a = akp_q;  mul_b = MUL_B_W'(err_q);   end
			OP_AI:   begin mul_a = aki_q;  mul_b = MUL_B_W'(err_q);   end
			OP_AD:   begin mul_a = akd_q;  mul_b = MUL_B_W'(derr_q);  end
			OP_SP:   begin mul_a = skp_q;  mul_b = MUL_B_W'(serr_q);  end
			OP_SI:   begin mul_a = ski_q;  mul_b = MUL_B_W'(serr_q);  end
			OP_SD:   begin mul_a = skd_q;  mul_b = MUL_B_W'(dserr_q); end
			OP_SF:   begin mul_a = skff_q; mul_b = MUL_B_W'(tgt_q);   end
			default: begin mul_a = '0;     mul_b = '0;                end
		endcase
	end

	always_comb begin
		cl_in  = acc_q;
		cl_bnd = so_bnd;
		case (cmd.op)
			OP_AD:   begin cl_in = ACC_W'(aint_q) + prod_fl;  cl_bnd = ai_bnd; end
			OP_AO:   begin cl_in = acc_q + ACC_W'(aint_q);    cl_bnd = ao_bnd; end
			OP_SD:   begin cl_in = ACC_W'(sint_q) + prod_ext; cl_bnd = si_bnd; end
			OP_SO:   begin cl_in = acc_q + ACC_W'(sint_q);    cl_bnd = so_bnd; end
			default: begin cl_in = acc_q;                     cl_bnd = so_bnd; end
		endcase
		cl_hit = 1'b1;
		if (cl_in > cl_bnd)
			cl_out = cl_bnd;
		else if (cl_in < -cl_bnd)
			cl_out = -cl_bnd;
		else begin
			cl_out = cl_in;
			cl_hit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			akp_q    <= '0;
			aki_q    <= '0;
			akd_q    <= '0;
			skp_q    <= '0;
			ski_q    <= '0;
			skd_q    <= '0;
			skff_q   <= '0;
			limits_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANGLE_KP:  akp_q    <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_ANGLE_KI:  aki_q    <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_ANGLE_KD:  akd_q    <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_SPEED_KP:  skp_q    <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_SPEED_KI:  ski_q    <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_SPEED_KD:  skd_q    <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_SPEED_KFF: skff_q   <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_LIMITS:    limits_q <= cfg_data;
				default:       limits_q <= limits_q;
			endcase
		end
	end

	// Loop state carried from item to item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aprev_q <= '0;
			aint_q  <= '0;
			sprev_q <= '0;
			sint_q  <= '0;
		end else begin
			case (cmd.op)
				OP_ERR:  aprev_q <= err_w;
				OP_AD:   aint_q  <= cl_out[INTEG_W-1:0];
				OP_SE:   sprev_q <= serr_w;
				OP_SD:   sint_q  <= cl_out[INTEG_W-1:0];
				default: aprev_q <= aprev_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load_in) begin
			sp_q   <= angle_setpoint;
			meas_q <= angle_measured;
			rpm_q  <= speed_measured;
			wrap_q <= wrap_enable;
		end
		case (cmd.op)
			OP_ERR: begin
				err_q  <= err_w;
				derr_q <= DERR_W'(err_w) - DERR_W'(aprev_q);
			end
			OP_AI:  acc_q <= prod_fl;
			OP_AS:  acc_q <= acc_q + prod_fl;
			OP_AO:  acc_q <= cl_out;
			OP_TGT: tgt_q <= trunc_whole(acc_q);
			OP_SE: begin
				serr_q  <= serr_w;
				dserr_q <= DSERR_W'(serr_w) - DSERR_W'(sprev_q);
			end
			OP_SI:  acc_q <= prod_ext;
			OP_SF:  acc_q <= acc_q + prod_ext;
			OP_SS:  acc_q <= acc_q + prod_ext;
			OP_SO: begin
				acc_q <= cl_out;
				sat_q <= cl_hit;
			end
			OP_OUT: begin
				drive_q   <= trunc_whole(acc_q);
				tgt_out_q <= tgt_q;
				sat_out_q <= sat_q;
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign drive_command   = drive_q;
	assign target_speed    = tgt_out_q;
	assign drive_saturated = sat_out_q;

endmodule

@@ design/cascaded_angle_speed_pid_top.sv @@
// ----------------------------------------------------------------------------
// Cascaded angle and speed PID controller
// Outer angle PID feeding an inner speed PID with feed-forward, fixed point.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    angle_setpoint, angle_measured,
//                                   speed_measured, wrap_enable
//   out      out_valid / out_stall  drive_command, target_speed, drive_saturated
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After acceptance the controller walks an item through 15 datapath
// steps using one shared 32x19 multiplier and one accumulator, with
// seven products and four add-and-clamp steps.
// Reset clears the gains, the limits and both loops' integrals and previous errors.
// A stalled result holds the last step until the output register is free;
// the next item can be accepted while a result waits.
// ----------------------------------------------------------------------------
module cascaded_angle_speed_pid_top #(
	parameter int ANGLE_FRAC_BITS = caspid_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int GAIN_FRAC_BITS  = caspid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [caspid_pkg::FIELD_W-1:0] angle_setpoint,
	input  logic signed [caspid_pkg::FIELD_W-1:0] angle_measured,
	input  logic signed [caspid_pkg::FIELD_W-1:0] speed_measured,
	input  logic                                  wrap_enable,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [caspid_pkg::FIELD_W-1:0] drive_command,
	output logic signed [caspid_pkg::FIELD_W-1:0] target_speed,
	output logic                                  drive_saturated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [caspid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [caspid_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import caspid_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	caspid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	caspid_dp #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.angle_setpoint  (angle_setpoint),
		.angle_measured  (angle_measured),
		.speed_measured  (speed_measured),
		.wrap_enable     (wrap_enable),
		.drive_command   (drive_command),
		.target_speed    (target_speed),
		.drive_saturated (drive_saturated)
	);

`ifndef SYNTHESIS
	// Only one item is in the loops at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item accepted while the loops were busy");

	// A new result appears only at the end of an item's sequence.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without an item in progress");
`endif

endmodule
